### rtl/core/ogb_pkg.sv
// ----------------------------------------------------------------------------
// Occupancy grid builder package
// Grid geometry, fixed-point constants, lookup tables and the command and
// status groups shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package ogb_pkg;

  localparam int GRID_SIDE   = 200;
  localparam int CELL_MM     = 100;
  localparam int MAX_RAYS    = 64;
  localparam int SINE_DEPTH  = 1024;

  localparam int CENTRE_MM   = GRID_SIDE * CELL_MM / 2;
  localparam int CENTRE_CELL = CENTRE_MM / CELL_MM;
  localparam int Q15_ONE     = 32768;
  localparam int CELL_Q      = CELL_MM * Q15_ONE;
  localparam int CENTRE_REM  = (CENTRE_MM % CELL_MM) * Q15_ONE;
  localparam int MAX_STEPS   = 4 * GRID_SIDE;

  localparam int ADDR_W  = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int IDX_W   = $clog2(GRID_SIDE) + 1;
  localparam int STEP_W  = $clog2(MAX_STEPS + 1);
  localparam int SIN_AW  = $clog2(SINE_DEPTH);
  localparam int REM_W   = $clog2(CELL_Q) + 3;
  localparam int RAY_W   = $clog2(MAX_RAYS + 1);
  localparam int PT_W    = $clog2(Q15_ONE + CENTRE_MM) + 2;

  // Reciprocal for the point index division; one correction step follows.
  localparam int PT_SHIFT = 24;
  localparam int PT_RECIP = (2 ** PT_SHIFT) / CELL_MM;

  localparam logic [31:0] RAY_STEP_PHASE = 32'd34192521;
  localparam logic [31:0] HEADING_PHASE  = 32'd1073197483;
  localparam logic [31:0] QUARTER_PHASE  = 32'h4000_0000;
  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOV    = 2'd1;
  localparam logic [11:0] HEIGHT_RESET = 12'hFF6;
  localparam logic [7:0]  FOV_RESET    = 8'd58;

  typedef enum logic [1:0] {
    CELL_UNKNOWN  = 2'd0,
    CELL_FREE     = 2'd1,
    CELL_OCCUPIED = 2'd2
  } cell_e;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_POINT = 2'd1,
    MODE_TRACE = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef logic [15:0]      sine_tab_t [SINE_DEPTH];
  typedef logic [31:0]      fan_tab_t  [256];
  typedef logic [RAY_W-1:0] rays_tab_t [256];

  // Quarter-wave sine in Q15 from a 13th-order Taylor series in Q30.
  function automatic sine_tab_t build_sine();
    sine_tab_t   t;
    logic [63:0] a;
    logic [63:0] term;
    longint      sum;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      a    = HALF_PI_Q30 * 64'(k) / SINE_DEPTH;
      term = a;
      sum  = longint'(a);
      for (int n = 1; n <= 6; n++) begin
        term = (term * a) >> 30;
        term = ((term * a) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      t[k] = 16'((sum + 16384) >> 15);
    end
    return t;
  endfunction

  function automatic fan_tab_t build_fan();
    fan_tab_t t;
    for (int f = 0; f < 256; f++) begin
      t[f] = 32'((64'(f) << 32) / 360);
    end
    return t;
  endfunction

  function automatic rays_tab_t build_rays();
    rays_tab_t   t;
    logic [31:0] n;
    for (int f = 0; f < 256; f++) begin
      n = 32'((64'(f) << 32) / 360) / RAY_STEP_PHASE;
      if (n > MAX_RAYS) begin
        n = MAX_RAYS;
      end
      t[f] = RAY_W'(n);
    end
    return t;
  endfunction

  localparam fan_tab_t  FAN_TAB  = build_fan();
  localparam rays_tab_t RAYS_TAB = build_rays();

  typedef struct packed {
    logic load;
    logic clr_step;
    logic pt_div;
    logic pt_fix;
    logic pt_write;
    logic rd_issue;
    logic rd_capture;
    logic ray_init;
    logic rom_cos;
    logic rom_sin;
    logic trig_latch;
    logic grid_read;
    logic step;
    logic next_ray;
    logic emit;
  } ogb_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic ray_done;
    logic ray_live;
    logic cell_occ;
    logic step_out;
    logic res_busy;
  } ogb_status_t;

endpackage

### rtl/core/ogb_if.sv
// ----------------------------------------------------------------------------
// Occupancy grid builder channels
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface ogb_item_if ();
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] point_x_mm;
  logic signed [15:0] point_y_mm;
  logic signed [15:0] point_z_mm;
  logic               point_valid;
  logic [7:0]         read_row;
  logic [7:0]         read_col;

  modport source (output valid, mode, point_x_mm, point_y_mm, point_z_mm, point_valid,
                  read_row, read_col, input ready);
  modport sink   (input valid, mode, point_x_mm, point_y_mm, point_z_mm, point_valid,
                  read_row, read_col, output ready);
endinterface

interface ogb_result_if ();
  logic       valid;
  logic       ready;
  logic [1:0] cell_state;
  logic [1:0] done_mode;

  modport source (output valid, cell_state, done_mode, input ready);
  modport sink   (input valid, cell_state, done_mode, output ready);
endinterface

interface ogb_cfg_if import ogb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### rtl/core/ogb_ctrl.sv
// ----------------------------------------------------------------------------
// Occupancy grid builder controller
// Sequences clear sweeps, point writes, cell reads and the ray walk.
// ----------------------------------------------------------------------------
module ogb_ctrl import ogb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [1:0]  in_mode_i,
  output logic        in_ready_o,
  input  ogb_status_t st_i,
  output ogb_cmd_t    cmd_o
);

  localparam logic [3:0] S_BOOT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_CLEAR    = 4'd2;
  localparam logic [3:0] S_PT_DIV   = 4'd3;
  localparam logic [3:0] S_PT_FIX   = 4'd4;
  localparam logic [3:0] S_PT_WR    = 4'd5;
  localparam logic [3:0] S_RD_ISS   = 4'd6;
  localparam logic [3:0] S_RD_CAP   = 4'd7;
  localparam logic [3:0] S_RAY_INIT = 4'd8;
  localparam logic [3:0] S_RAY_CHK  = 4'd9;
  localparam logic [3:0] S_RAY_SIN  = 4'd10;
  localparam logic [3:0] S_RAY_TRIG = 4'd11;
  localparam logic [3:0] S_RAY_RD   = 4'd12;
  localparam logic [3:0] S_RAY_STEP = 4'd13;
  localparam logic [3:0] S_DONE     = 4'd14;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_BOOT: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (in_mode_i)
            MODE_CLEAR: state_d = S_CLEAR;
            MODE_POINT: state_d = S_PT_DIV;
            MODE_TRACE: state_d = S_RAY_INIT;
            default:    state_d = S_RD_ISS;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.clr_last) state_d = S_DONE;
      end
      S_PT_DIV: begin
        cmd_o.pt_div = 1'b1;
        state_d      = S_PT_FIX;
      end
      S_PT_FIX: begin
        cmd_o.pt_fix = 1'b1;
        state_d      = S_PT_WR;
      end
      S_PT_WR: begin
        cmd_o.pt_write = 1'b1;
        state_d        = S_DONE;
      end
      S_RD_ISS: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_RD_CAP;
      end
      S_RD_CAP: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = S_DONE;
      end
      S_RAY_INIT: begin
        cmd_o.ray_init = 1'b1;
        state_d        = S_RAY_CHK;
      end
      S_RAY_CHK: begin
        if (st_i.ray_done) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rom_cos = 1'b1;
          state_d       = S_RAY_SIN;
        end
      end
      S_RAY_SIN: begin
        cmd_o.rom_sin = 1'b1;
        state_d       = S_RAY_TRIG;
      end
      S_RAY_TRIG: begin
        cmd_o.trig_latch = 1'b1;
        state_d          = S_RAY_RD;
      end
      S_RAY_RD: begin
        if (st_i.ray_live) begin
          cmd_o.grid_read = 1'b1;
          state_d         = S_RAY_STEP;
        end else begin
          cmd_o.next_ray = 1'b1;
          state_d        = S_RAY_CHK;
        end
      end
      S_RAY_STEP: begin
        if (st_i.cell_occ) begin
          cmd_o.next_ray = 1'b1;
          state_d        = S_RAY_CHK;
        end else begin
          cmd_o.step = 1'b1;
          if (st_i.step_out) begin
            cmd_o.next_ray = 1'b1;
            state_d        = S_RAY_CHK;
          end else begin
            state_d = S_RAY_RD;
          end
        end
      end
      S_DONE: begin
        if (!st_i.res_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BOOT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/ogb_dp.sv
// ----------------------------------------------------------------------------
// Occupancy grid builder datapath
// Grid memory, sine ROM, configuration registers, ray stepper and result
// register.
// ----------------------------------------------------------------------------
module ogb_dp import ogb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ogb_cmd_t              cmd_i,
  output ogb_status_t           st_o,
  input  logic [1:0]            mode_i,
  input  logic signed [15:0]    point_x_mm_i,
  input  logic signed [15:0]    point_y_mm_i,
  input  logic signed [15:0]    point_z_mm_i,
  input  logic                  point_valid_i,
  input  logic [7:0]            read_row_i,
  input  logic [7:0]            read_col_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic [1:0]            cell_state_o,
  output logic [1:0]            done_mode_o
);

  localparam sine_tab_t SINE_ROM = build_sine();
  localparam logic signed [REM_W-1:0] CELL_Q_S = REM_W'(CELL_Q);

  // Configuration registers.
  logic signed [11:0] thr_q;
  logic [7:0]         fov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= HEIGHT_RESET;
      fov_q <= FOV_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_HEIGHT) thr_q <= cfg_data_i[11:0];
      if (cfg_idx_i == REG_FOV)    fov_q <= cfg_data_i[7:0];
    end
  end

  // Item capture.
  logic [1:0]        mode_q;
  logic [ADDR_W-1:0] rd_addr_q;
  logic              rd_ok_q;
  logic [PT_W-1:0]   ox_q, oz_q;
  logic              pt_ok_q;
  logic [PT_W-1:0]   ox_d, oz_d;
  logic [16:0]       neg_y;
  logic              tall;

  assign ox_d  = {{(PT_W-16){point_x_mm_i[15]}}, point_x_mm_i} + PT_W'(CENTRE_MM);
  assign oz_d  = {{(PT_W-16){point_z_mm_i[15]}}, point_z_mm_i} + PT_W'(CENTRE_MM);
  assign neg_y = 17'd0 - {point_y_mm_i[15], point_y_mm_i};
  assign tall  = $signed(neg_y) > $signed({{5{thr_q[11]}}, thr_q});

  // Point index: reciprocal estimate, then one correction.
  logic [PT_W-1:0] qx0_q, qz0_q, qx_q, qz_q;
  logic [63:0]     rx, rz;
  logic            pt_hit;
  logic [ADDR_W-1:0] pt_addr;

  assign rx      = 64'(ox_q) - 64'(qx0_q) * 64'(CELL_MM);
  assign rz      = 64'(oz_q) - 64'(qz0_q) * 64'(CELL_MM);
  assign pt_hit  = pt_ok_q && (qx_q < PT_W'(GRID_SIDE)) && (qz_q < PT_W'(GRID_SIDE));
  assign pt_addr = ADDR_W'(qz_q * GRID_SIDE + qx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q    <= mode_i;
      rd_addr_q <= ADDR_W'(read_row_i * GRID_SIDE + read_col_i);
      rd_ok_q   <= (read_row_i < GRID_SIDE) && (read_col_i < GRID_SIDE);
      ox_q      <= ox_d;
      oz_q      <= oz_d;
      pt_ok_q   <= point_valid_i && tall && !ox_d[PT_W-1] && !oz_d[PT_W-1];
    end
    if (cmd_i.pt_div) begin
      qx0_q <= PT_W'((64'(ox_q) * 64'(PT_RECIP)) >> PT_SHIFT);
      qz0_q <= PT_W'((64'(oz_q) * 64'(PT_RECIP)) >> PT_SHIFT);
    end
    if (cmd_i.pt_fix) begin
      qx_q <= (rx >= 64'(CELL_MM)) ? qx0_q + 1'b1 : qx0_q;
      qz_q <= (rz >= 64'(CELL_MM)) ? qz0_q + 1'b1 : qz0_q;
    end
  end

  // Ray state.
  logic [31:0]               theta_q;
  logic [RAY_W-1:0]          ray_n_q, nrays_q;
  logic signed [REM_W-1:0]   dcol_q, drow_q, rem_c_q, rem_r_q;
  logic [IDX_W-1:0]          col_q, row_q;
  logic [STEP_W-1:0]         steps_q;

  // Sine lookup with quadrant folding.
  logic [31:0]         phase;
  logic [SIN_AW+1:0]   sidx;
  logic [SIN_AW:0]     mirror;
  logic [SIN_AW-1:0]   rom_idx;
  logic [15:0]         rom_q;
  logic                full_q, neg_q;
  logic signed [16:0]  trig, trig_s;
  logic signed [REM_W-1:0] delta;

  assign phase   = cmd_i.rom_cos ? theta_q + QUARTER_PHASE : theta_q;
  assign sidx    = phase[31 -: SIN_AW+2];
  assign mirror  = (SIN_AW+1)'(SINE_DEPTH) - {1'b0, sidx[SIN_AW-1:0]};
  assign rom_idx = sidx[SIN_AW] ? mirror[SIN_AW-1:0] : sidx[SIN_AW-1:0];
  assign trig    = full_q ? 17'sd32768 : $signed({1'b0, rom_q});
  assign trig_s  = neg_q ? -trig : trig;
  assign delta   = REM_W'(trig_s * CELL_MM);

  always_ff @(posedge clk_i) begin
    rom_q  <= SINE_ROM[rom_idx];
    full_q <= sidx[SIN_AW] && (sidx[SIN_AW-1:0] == '0);
    neg_q  <= sidx[SIN_AW+1];
  end

  // At most one cell step in each axis; the offset moves by at most one cell.
  logic signed [REM_W-1:0] sum_c, sum_r;
  logic                    neg_c, neg_r, step_out;
  logic [ADDR_W-1:0]       ray_addr;

  assign sum_c    = rem_c_q + dcol_q;
  assign sum_r    = rem_r_q + drow_q;
  assign neg_c    = sum_c[REM_W-1] && (col_q == '0);
  assign neg_r    = sum_r[REM_W-1] && (row_q == '0);
  assign step_out = neg_c || neg_r;
  assign ray_addr = ADDR_W'(row_q * GRID_SIDE + col_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ray_init) begin
      theta_q <= HEADING_PHASE - (FAN_TAB[fov_q] >> 1);
      ray_n_q <= '0;
      nrays_q <= RAYS_TAB[fov_q];
    end
    if (cmd_i.next_ray) begin
      theta_q <= theta_q + RAY_STEP_PHASE;
      ray_n_q <= ray_n_q + 1'b1;
    end
    if (cmd_i.rom_sin) dcol_q <= delta;
    if (cmd_i.trig_latch) begin
      drow_q  <= delta;
      col_q   <= IDX_W'(CENTRE_CELL);
      row_q   <= IDX_W'(CENTRE_CELL);
      rem_c_q <= REM_W'(CENTRE_REM);
      rem_r_q <= REM_W'(CENTRE_REM);
      steps_q <= '0;
    end
    if (cmd_i.step && !step_out) begin
      steps_q <= steps_q + 1'b1;
      if (sum_c >= CELL_Q_S) begin
        col_q   <= col_q + 1'b1;
        rem_c_q <= sum_c - CELL_Q_S;
      end else if (sum_c[REM_W-1]) begin
        col_q   <= col_q - 1'b1;
        rem_c_q <= sum_c + CELL_Q_S;
      end else begin
        rem_c_q <= sum_c;
      end
      if (sum_r >= CELL_Q_S) begin
        row_q   <= row_q + 1'b1;
        rem_r_q <= sum_r - CELL_Q_S;
      end else if (sum_r[REM_W-1]) begin
        row_q   <= row_q - 1'b1;
        rem_r_q <= sum_r + CELL_Q_S;
      end else begin
        rem_r_q <= sum_r;
      end
    end
  end

  // Clear sweep counter.
  logic [ADDR_W-1:0] clr_addr_q;
  logic              clr_last;

  assign clr_last = (clr_addr_q == ADDR_W'(GRID_SIDE * GRID_SIDE - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_addr_q <= clr_last ? '0 : clr_addr_q + 1'b1;
    end
  end

  // Grid memory.
  logic [1:0]        grid_mem [GRID_SIDE * GRID_SIDE];
  logic [1:0]        grid_rdata_q;
  logic              g_we;
  logic [ADDR_W-1:0] g_waddr, g_raddr;
  logic [1:0]        g_wdata;

  always_comb begin
    g_we    = 1'b0;
    g_waddr = ray_addr;
    g_wdata = CELL_FREE;
    if (cmd_i.clr_step) begin
      g_we    = 1'b1;
      g_waddr = clr_addr_q;
      g_wdata = CELL_UNKNOWN;
    end else if (cmd_i.pt_write) begin
      g_we    = pt_hit;
      g_waddr = pt_addr;
      g_wdata = CELL_OCCUPIED;
    end else if (cmd_i.step) begin
      g_we = 1'b1;
    end
  end

  assign g_raddr = cmd_i.rd_issue ? rd_addr_q : ray_addr;

  always_ff @(posedge clk_i) begin
    if (g_we) grid_mem[g_waddr] <= g_wdata;
    grid_rdata_q <= grid_mem[g_raddr];
  end

  // Result.
  logic [1:0] cell_q;
  logic       res_valid_q;
  logic [1:0] res_cell_q, res_mode_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) cell_q <= CELL_UNKNOWN;
    if (cmd_i.rd_capture) cell_q <= rd_ok_q ? grid_rdata_q : CELL_UNKNOWN;
    if (cmd_i.emit) begin
      res_cell_q <= cell_q;
      res_mode_q <= mode_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign cell_state_o = res_cell_q;
  assign done_mode_o  = res_mode_q;

  assign st_o.clr_last = clr_last;
  assign st_o.ray_done = (ray_n_q == nrays_q);
  assign st_o.ray_live = (col_q < IDX_W'(GRID_SIDE)) && (row_q < IDX_W'(GRID_SIDE))
                         && (steps_q < STEP_W'(MAX_STEPS));
  assign st_o.cell_occ = (grid_rdata_q == CELL_OCCUPIED);
  assign st_o.step_out = step_out;
  assign st_o.res_busy = res_valid_q && !res_ready_i;

endmodule

### rtl/core/occupancy_grid_builder.sv
// One item is in flight at a time; the next can be taken as soon as the result is
// offered. A ray visits cells until it leaves the grid, runs out of steps or meets an
// occupied cell; each visited cell takes a registered grid read and then a step that
// marks it free unless it is occupied.
// Reset: the grid is swept to unknown; only register writes are taken meanwhile.
// ----------------------------------------------------------------------------
// Occupancy grid builder
// Keeps a square grid of unknown, free and occupied cells around the sensor,
// marks obstacle points, casts a fan of free-space rays, reads cells back and clears the grid.
// ----------------------------------------------------------------------------
module occupancy_grid_builder import ogb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ogb_item_if.sink    item_i,
  ogb_result_if.source result_o,
  ogb_cfg_if.sink     cfg_i
);

  ogb_cmd_t    cmd;
  ogb_status_t st;

  // Register writes complete in the cycle they are offered. The user must write the
  // port only while idle, so nothing in flight sees a change; the block does not enforce it.
  assign cfg_i.ready = 1'b1;

  // The controller owns sequencing: it takes one item from IDLE, walks the
  // work of its mode, and hands the result to the output register, which
  // may still be holding the previous result when the item arrives.
  ogb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_mode_i  (item_i.mode),
    .in_ready_o (item_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // The datapath holds the grid memory, the sine table, the ray stepper
  // that tracks each cell index with a remainder instead of a divider,
  // and the output register of the result channel.
  ogb_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .mode_i        (item_i.mode),
    .point_x_mm_i  (item_i.point_x_mm),
    .point_y_mm_i  (item_i.point_y_mm),
    .point_z_mm_i  (item_i.point_z_mm),
    .point_valid_i (item_i.point_valid),
    .read_row_i    (item_i.read_row),
    .read_col_i    (item_i.read_col),
    .cfg_we_i      (cfg_i.valid && cfg_i.ready),
    .cfg_idx_i     (cfg_i.reg_index),
    .cfg_data_i    (cfg_i.wdata),
    .res_valid_o   (result_o.valid),
    .res_ready_i   (result_o.ready),
    .cell_state_o  (result_o.cell_state),
    .done_mode_o   (result_o.done_mode)
  );

  // Taking an item drops the input ready, so items are never taken on back-to-back cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> !item_i.ready)
    else $error("input taken on back-to-back cycles");

  // Only a read reports a cell state other than unknown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.done_mode != MODE_READ) |-> result_o.cell_state == CELL_UNKNOWN)
    else $error("cell state reported for a non-read item");

  // A cell state never carries the unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.cell_state != 2'd3)
    else $error("cell state out of range");

endmodule
